[rtl/pmc_pkg.sv]
// ----------------------------------------------------------------------------
// pmc_pkg: shared constants and a helper function for the momentum corrector
// ----------------------------------------------------------------------------
`default_nettype none
package pmc_pkg;

   localparam int NUM_PAIRS    = 6;
   localparam int CORDIC_STEPS = 30;
   localparam int CSR_IDX_W    = 3;

   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [15:0] ANGLE_MAX   = 16'd46080;
   localparam logic [39:0] ACC_MAX     = 40'h7F_FFFF_FFFF;
   localparam logic [39:0] ACC_MIN     = 40'h80_0000_0000;

   // atan(2^-i) in Q2.30, rounded
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      logic [31:0] r;
      begin
         case (i)
            5'd0:  r = 32'd843314857;
            5'd1:  r = 32'd497837829;
            5'd2:  r = 32'd263043837;
            5'd3:  r = 32'd133525159;
            5'd4:  r = 32'd67021687;
            5'd5:  r = 32'd33543516;
            5'd6:  r = 32'd16775851;
            5'd7:  r = 32'd8388437;
            5'd8:  r = 32'd4194283;
            5'd9:  r = 32'd2097149;
            5'd10: r = 32'd1048576;
            5'd11: r = 32'd524288;
            5'd12: r = 32'd262144;
            5'd13: r = 32'd131072;
            5'd14: r = 32'd65536;
            5'd15: r = 32'd32768;
            5'd16: r = 32'd16384;
            5'd17: r = 32'd8192;
            5'd18: r = 32'd4096;
            5'd19: r = 32'd2048;
            5'd20: r = 32'd1024;
            5'd21: r = 32'd512;
            5'd22: r = 32'd256;
            5'd23: r = 32'd128;
            5'd24: r = 32'd64;
            5'd25: r = 32'd32;
            5'd26: r = 32'd16;
            5'd27: r = 32'd8;
            5'd28: r = 32'd4;
            5'd29: r = 32'd2;
            default: r = 32'd0;
         endcase
         return r;
      end
   endfunction

endpackage
`default_nettype wire

[rtl/pmc_stream_if.sv]
// ----------------------------------------------------------------------------
// pmc_stream_if: valid/ready channel carrying a generic payload
// ----------------------------------------------------------------------------
`default_nettype none
interface pmc_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/pmc_sqrt_stage.sv]
// ----------------------------------------------------------------------------
// pmc_sqrt_stage: one bit of a pipelined restoring square root
// ----------------------------------------------------------------------------
`default_nettype none
module pmc_sqrt_stage #(
   parameter int W   = 64,
   parameter int BIT = 0
) (
   input  wire logic [W-1:0]   rem_in,
   input  wire logic [W/2-1:0] root_in,
   output logic      [W-1:0]   rem_out,
   output logic      [W/2-1:0] root_out
);
   logic [W-1:0] trial;

   // test root|1 at position BIT
   always_comb begin
      trial = ({{(W/2){1'b0}}, root_in} << (BIT + 1))
              | ({{(W-1){1'b0}}, 1'b1} << (2 * BIT));
      if (rem_in >= trial) begin
         rem_out  = rem_in - trial;
         root_out = root_in | ({{(W/2-1){1'b0}}, 1'b1} << BIT);
      end else begin
         rem_out  = rem_in;
         root_out = root_in;
      end
   end
endmodule
`default_nettype wire

[rtl/proton_momentum_correction_unit.sv]
// ----------------------------------------------------------------------------
// proton_momentum_correction_unit: corrected proton momentum per track
// ----------------------------------------------------------------------------
// Use: one track (px, py, pz, vertex_z) enters per req_ beat and one result
// (corrected and raw momentum, polar angle, branch and saturation flags)
// leaves per rsp_ beat, in order. Polynomial coefficients are written on the
// csr_ port while the unit is idle.
// Throughput: one beat per cycle unless the receiver stalls. Pipeline stages
// in order: squares, 8 sqrt stages of 4 root bits with both roots in
// parallel, CORDIC pre-rotation, 30 CORDIC stages, angle scale, angle
// divide, branch select, a multiply stage and a shift/add/clamp stage per
// Horner step, final scale, output register.
// The whole pipe advances when its last stage is empty or accepted, so a
// stalled receiver freezes every stage in place; nothing is lost.
// Reset clears all valid bits and the coefficient registers.
// ----------------------------------------------------------------------------
`default_nettype none
module proton_momentum_correction_unit #(
   parameter int POLY_TERMS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [23:0] req_px,
   input  wire logic [23:0] req_py,
   input  wire logic [23:0] req_pz,
   input  wire logic [15:0] req_vertex_z,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [23:0]      rsp_corrected_momentum,
   output logic [23:0]      rsp_raw_momentum,
   output logic [15:0]      rsp_polar_angle,
   output logic             rsp_used_up_branch,
   output logic             rsp_saturated,
   input  wire logic        csr_write_enable,
   input  wire logic [pmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0] csr_write_data
);
   import pmc_pkg::*;

   localparam int SQ_STAGES = 32;
   localparam int NH        = POLY_TERMS - 1;

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // coefficient registers
   logic [63:0] coeff_ff [NUM_PAIRS];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_PAIRS; k++) coeff_ff[k] <= '0;
      end else if (csr_write_enable && csr_index < CSR_IDX_W'(NUM_PAIRS)) begin
         coeff_ff[csr_index] <= csr_write_data;
      end
   end

   // ---- stage 0: squares ----
   logic        v0_ff;
   logic [63:0] tot0_ff, perp0_ff;
   logic signed [23:0] pz0_ff;
   logic signed [15:0] vz0_ff;
   logic signed [47:0] sx, sy, sz;
   always_comb begin
      sx = 48'($signed(req_px)) * 48'($signed(req_px));
      sy = 48'($signed(req_py)) * 48'($signed(req_py));
      sz = 48'($signed(req_pz)) * 48'($signed(req_pz));
   end
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_valid;
      if (adv) begin
         perp0_ff <= {15'd0, 49'(sx) + 49'(sy)} << 16;
         tot0_ff  <= 64'(sx) + 64'(sy) + 64'(sz);
         pz0_ff   <= $signed(req_pz);
         vz0_ff   <= $signed(req_vertex_z);
      end
   end

   // ---- sqrt pipeline: 4 bits of root per stage, two roots in parallel ----
   localparam int SQ_PIPE = SQ_STAGES / 4;
   logic [63:0] ra_ff [SQ_PIPE+1];
   logic [31:0] qa_ff [SQ_PIPE+1];
   logic [63:0] rb_ff [SQ_PIPE+1];
   logic [31:0] qb_ff [SQ_PIPE+1];
   logic        sv_ff [SQ_PIPE+1];
   logic signed [23:0] spz_ff [SQ_PIPE+1];
   logic signed [15:0] svz_ff [SQ_PIPE+1];
   always_comb begin
      ra_ff[0] = tot0_ff;  qa_ff[0] = '0;
      rb_ff[0] = perp0_ff; qb_ff[0] = '0;
      sv_ff[0] = v0_ff; spz_ff[0] = pz0_ff; svz_ff[0] = vz0_ff;
   end
   genvar g, h;
   generate
      for (g = 0; g < SQ_PIPE; g++) begin : g_sq
         logic [63:0] ra [5];
         logic [31:0] qa [5];
         logic [63:0] rb [5];
         logic [31:0] qb [5];
         assign ra[0] = ra_ff[g]; assign qa[0] = qa_ff[g];
         assign rb[0] = rb_ff[g]; assign qb[0] = qb_ff[g];
         for (h = 0; h < 4; h++) begin : g_b
            pmc_sqrt_stage #(.W(64), .BIT(31 - 4*g - h)) u_a (
               .rem_in(ra[h]), .root_in(qa[h]), .rem_out(ra[h+1]), .root_out(qa[h+1]));
            pmc_sqrt_stage #(.W(64), .BIT(31 - 4*g - h)) u_b (
               .rem_in(rb[h]), .root_in(qb[h]), .rem_out(rb[h+1]), .root_out(qb[h+1]));
         end
         always_ff @(posedge clock) begin
            if (reset) sv_ff[g+1] <= 1'b0;
            else if (adv) sv_ff[g+1] <= sv_ff[g];
            if (adv) begin
               ra_ff[g+1] <= ra[4]; qa_ff[g+1] <= qa[4];
               rb_ff[g+1] <= rb[4]; qb_ff[g+1] <= qb[4];
               spz_ff[g+1] <= spz_ff[g]; svz_ff[g+1] <= svz_ff[g];
            end
         end
      end
   endgenerate

   // ---- CORDIC setup: pre-rotation for negative z ----
   logic [23:0] p_c;
   logic signed [15:0] vz_c;
   logic signed [35:0] cx_s, cy_s;
   logic signed [33:0] ca_s;
   logic cv_s;
   logic signed [35:0] z_w, rho_w;
   always_comb begin
      z_w   = 36'($signed(spz_ff[SQ_PIPE])) <<< 8;
      rho_w = $signed({4'd0, qb_ff[SQ_PIPE]});
      if (z_w < 0) begin
         cx_s = rho_w; cy_s = -z_w; ca_s = $signed({2'b00, HALF_PI_Q30});
      end else begin
         cx_s = z_w; cy_s = rho_w; ca_s = '0;
      end
   end
   logic signed [35:0] cx_ff [CORDIC_STEPS+1];
   logic signed [35:0] cy_ff [CORDIC_STEPS+1];
   logic signed [33:0] ca_ff [CORDIC_STEPS+1];
   logic               cz_ff [CORDIC_STEPS+1];
   logic               cvv_ff[CORDIC_STEPS+1];
   logic [23:0]        cp_ff [CORDIC_STEPS+1];
   logic signed [15:0] cvz_ff[CORDIC_STEPS+1];
   assign p_c = qa_ff[SQ_PIPE][23:0];
   assign vz_c = svz_ff[SQ_PIPE];
   assign cv_s = sv_ff[SQ_PIPE];
   always_ff @(posedge clock) begin
      if (reset) cvv_ff[0] <= 1'b0;
      else if (adv) cvv_ff[0] <= cv_s;
      if (adv) begin
         cx_ff[0] <= cx_s; cy_ff[0] <= cy_s; ca_ff[0] <= ca_s;
         cz_ff[0] <= (z_w == 0) && (rho_w == 0);
         cp_ff[0] <= p_c; cvz_ff[0] <= vz_c;
      end
   end
   generate
      for (g = 0; g < CORDIC_STEPS; g++) begin : g_cor
         logic signed [35:0] dx, dy, nx, ny;
         logic signed [33:0] na, at;
         always_comb begin
            dx = cx_ff[g] ; dy = cy_ff[g];
            dx = cy_ff[g] >>> g;
            dy = cx_ff[g] >>> g;
            at = $signed({2'b00, atan_q30(5'(g))});
            if (cy_ff[g] > 0) begin
               nx = cx_ff[g] + dx; ny = cy_ff[g] - dy; na = ca_ff[g] + at;
            end else begin
               nx = cx_ff[g] - dx; ny = cy_ff[g] + dy; na = ca_ff[g] - at;
            end
         end
         always_ff @(posedge clock) begin
            if (reset) cvv_ff[g+1] <= 1'b0;
            else if (adv) cvv_ff[g+1] <= cvv_ff[g];
            if (adv) begin
               cx_ff[g+1] <= nx; cy_ff[g+1] <= ny; ca_ff[g+1] <= na;
               cz_ff[g+1] <= cz_ff[g]; cp_ff[g+1] <= cp_ff[g];
               cvz_ff[g+1] <= cvz_ff[g];
            end
         end
      end
   endgenerate

   // ---- angle scale: round(a*146688 / 10*2^30) ----
   logic        av_ff;
   logic [51:0] aprod_ff;
   logic        az_ff;
   logic [23:0] ap_ff;
   logic signed [15:0] avz_ff;
   logic [32:0] a_pos;
   assign a_pos = ca_ff[CORDIC_STEPS][33] ? 33'd0 : 33'(ca_ff[CORDIC_STEPS]);
   always_ff @(posedge clock) begin
      if (reset) av_ff <= 1'b0;
      else if (adv) av_ff <= cvv_ff[CORDIC_STEPS];
      if (adv) begin
         aprod_ff <= 52'(a_pos) * 52'd146688 + (52'd5 << 30);
         az_ff <= cz_ff[CORDIC_STEPS]; ap_ff <= cp_ff[CORDIC_STEPS];
         avz_ff <= cvz_ff[CORDIC_STEPS];
      end
   end
   // divide by 10*2^30: shift by 31, then by 5 via reciprocal
   logic [20:0] q5_in;
   logic [42:0] q5_m;
   logic [20:0] q5;
   logic [15:0] th_c;
   always_comb begin
      q5_in = 21'(aprod_ff >> 31);
      q5_m  = 43'(q5_in) * 43'd419431;   // ceil(2^21/5)
      q5    = 21'(q5_m >> 21);
      if (q5_in - q5 * 21'd5 >= 21'd5) q5 = q5 + 21'd1;
      if (q5 * 21'd5 > q5_in) q5 = q5 - 21'd1;
      if (az_ff) th_c = '0;
      else if (q5 > 21'(ANGLE_MAX)) th_c = ANGLE_MAX;
      else th_c = q5[15:0];
   end

   // angle register ahead of the branch compares
   logic        tv_ff;
   logic [15:0] tth_ff;
   logic [23:0] tp_ff;
   logic signed [15:0] tvz_ff;
   always_ff @(posedge clock) begin
      if (reset) tv_ff <= 1'b0;
      else if (adv) tv_ff <= av_ff;
      if (adv) begin
         tth_ff <= th_c; tp_ff <= ap_ff; tvz_ff <= avz_ff;
      end
   end

   // ---- branch select ----
   logic        bv_ff, bup_ff;
   logic [15:0] bth_ff;
   logic [23:0] bp_ff;
   logic        up_c;
   logic signed [25:0] vz20, thm;
   logic [33:0] lhs86;
   logic [31:0] p100;
   always_comb begin
      vz20  = 26'(tvz_ff) * 26'sd20;
      thm   = $signed({10'd0, tth_ff});
      lhs86 = 34'(tth_ff) * 34'd256 + 34'(tp_ff) * 34'd200;
      p100  = 32'(tp_ff) * 32'd100;
      if (tth_ff >= 16'd17920) up_c = 1'b1;
      else if (tth_ff < 16'd7680 || vz20 >= thm - 26'sd10240 || lhs86 <= 34'd5636096)
         up_c = 1'b0;
      else if (thm > vz20 + 26'sd12800) up_c = 1'b1;
      else up_c = !(p100 < 32'd3735552);
   end
   always_ff @(posedge clock) begin
      if (reset) bv_ff <= 1'b0;
      else if (adv) bv_ff <= tv_ff;
      if (adv) begin
         bup_ff <= up_c; bth_ff <= tth_ff; bp_ff <= tp_ff;
      end
   end

   // ---- Horner: per step one multiply stage then one shift/add/clamp ----
   function automatic logic signed [39:0] coef(input int t, input logic up);
      logic [31:0] c;
      begin
         if (t >= NUM_PAIRS) c = '0;
         else c = up ? coeff_ff[t][63:32] : coeff_ff[t][31:0];
         return 40'($signed(c));
      end
   endfunction

   logic signed [39:0] hacc_ff [NH+1];
   logic               hv_ff   [NH+1];
   logic               hup_ff  [NH+1];
   logic [15:0]        hth_ff  [NH+1];
   logic [23:0]        hp_ff   [NH+1];
   always_comb begin
      hacc_ff[0] = coef(POLY_TERMS - 1, bup_ff);
      hv_ff[0] = bv_ff; hup_ff[0] = bup_ff; hth_ff[0] = bth_ff; hp_ff[0] = bp_ff;
   end
   generate
      for (g = 0; g < NH; g++) begin : g_hor
         logic signed [64:0] m_ff;
         logic               mv_ff, mup_ff;
         logic [15:0]        mth_ff;
         logic [23:0]        mp_ff;
         logic signed [49:0] s;
         logic signed [39:0] nacc;
         always_ff @(posedge clock) begin
            if (reset) mv_ff <= 1'b0;
            else if (adv) mv_ff <= hv_ff[g];
            if (adv) begin
               m_ff <= 65'(hacc_ff[g]) * $signed({41'd0, hp_ff[g]});
               mup_ff <= hup_ff[g]; mth_ff <= hth_ff[g]; mp_ff <= hp_ff[g];
            end
         end
         always_comb begin
            s = 50'(m_ff >>> 16) + 50'(coef(POLY_TERMS - 2 - g, mup_ff));
            if (s > 50'($signed(ACC_MAX))) nacc = $signed(ACC_MAX);
            else if (s < 50'($signed(ACC_MIN))) nacc = $signed(ACC_MIN);
            else nacc = s[39:0];
         end
         always_ff @(posedge clock) begin
            if (reset) hv_ff[g+1] <= 1'b0;
            else if (adv) hv_ff[g+1] <= mv_ff;
            if (adv) begin
               hacc_ff[g+1] <= nacc; hup_ff[g+1] <= mup_ff;
               hth_ff[g+1] <= mth_ff; hp_ff[g+1] <= mp_ff;
            end
         end
      end
   endgenerate

   // ---- final scale p*(2^24+poly) >> 24, saturate ----
   logic        fv_ff, fup_ff;
   logic [64:0] fprod_ff;
   logic [15:0] fth_ff;
   logic [23:0] fp_ff;
   logic [39:0] poly_pos;
   assign poly_pos = hacc_ff[NH][39] ? 40'd0 : hacc_ff[NH];
   always_ff @(posedge clock) begin
      if (reset) fv_ff <= 1'b0;
      else if (adv) fv_ff <= hv_ff[NH];
      if (adv) begin
         fprod_ff <= 65'(hp_ff[NH]) * (65'(poly_pos) + (65'd1 << 24));
         fup_ff <= hup_ff[NH]; fth_ff <= hth_ff[NH]; fp_ff <= hp_ff[NH];
      end
   end

   logic [40:0] corr_w;
   assign corr_w = fprod_ff[64:24];
   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else if (adv) rsp_valid <= fv_ff;
      if (adv) begin
         rsp_saturated <= corr_w > 41'hFFFFFF;
         rsp_corrected_momentum <= (corr_w > 41'hFFFFFF) ? 24'hFFFFFF : corr_w[23:0];
         rsp_raw_momentum <= fp_ff;
         rsp_polar_angle <= fth_ff;
         rsp_used_up_branch <= fup_ff;
      end
   end
endmodule
`default_nettype wire

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: momentum corrector testbench
// ----------------------------------------------------------------------------
// Streams tracks through the corrector over several coefficient settings and
// idle patterns. Each accepted track is run through a local model of the
// magnitude, CORDIC angle, branch choice and Horner correction; every result
// beat is compared field by field with the oldest prediction, in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
   import pmc_pkg::*;

   typedef struct packed {
      logic [23:0] px;
      logic [23:0] py;
      logic [23:0] pz;
      logic [15:0] vertex_z;
   } track_type;

   typedef struct packed {
      logic [23:0] corrected_momentum;
      logic [23:0] raw_momentum;
      logic [15:0] polar_angle;
      logic        used_up_branch;
      logic        saturated;
   } correction_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEFF0, CSR_COEFF1, CSR_COEFF2, CSR_COEFF3, CSR_COEFF4, CSR_COEFF5,
      CSR_SPARE6, CSR_SPARE7
   } csr_index_type;

   localparam int POLY_TERMS  = 6;
   localparam int DRAIN_WAIT  = 100;
   localparam int LONG_HOLD   = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0] csr_write_data = '0;

   pmc_stream_if #(.payload_type(track_type))      req_if ();
   pmc_stream_if #(.payload_type(correction_type)) rsp_if ();

   proton_momentum_correction_unit #(.POLY_TERMS(POLY_TERMS)) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_if.valid),
      .req_ready              (req_if.ready),
      .req_px                 (req_if.data.px),
      .req_py                 (req_if.data.py),
      .req_pz                 (req_if.data.pz),
      .req_vertex_z           (req_if.data.vertex_z),
      .rsp_valid              (rsp_if.valid),
      .rsp_ready              (rsp_if.ready),
      .rsp_corrected_momentum (rsp_if.data.corrected_momentum),
      .rsp_raw_momentum       (rsp_if.data.raw_momentum),
      .rsp_polar_angle        (rsp_if.data.polar_angle),
      .rsp_used_up_branch     (rsp_if.data.used_up_branch),
      .rsp_saturated          (rsp_if.data.saturated),
      .csr_write_enable       (csr_write_enable),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   always #5 clock = ~clock;

   // local copy of the coefficient registers
   logic [63:0] coeff_pairs [NUM_PAIRS];

   track_type      pending_tracks [$];
   correction_type expected_results [$];
   int          error_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          hold_arm = 0;
   int          hold_seen = 0;
   int          hold_left = 0;
   bit          track_taken = 1'b0;

   // ---------------- model ----------------
   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // atan(2^-i) in Q2.30 from the arctangent series; i = 0 uses a constant
   function automatic longint atan_entry(int i);
      longint s;
      longint term;
      int k, e;
      s = 0;
      if (i == 0) return 64'sd843314857;
      for (k = 0; k < 64; k++) begin
         e = i * (2 * k + 1);
         if (e > 62) break;
         term = longint'((64'd1 << (62 - e)) / longint'(2 * k + 1));
         s = (k % 2) ? s - term : s + term;
      end
      return (s + (64'sd1 <<< 31)) >>> 32;
   endfunction

   function automatic longint angle_q8_8(longint z, longint rho);
      longint x, y, a, t, dx, dy;
      x = z;
      y = rho;
      a = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         x = y;
         y = -t;
         a = longint'(HALF_PI_Q30);
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx;
            y -= dy;
            a += atan_entry(i);
         end else begin
            x -= dx;
            y += dy;
            a -= atan_entry(i);
         end
      end
      if (a < 0) a = 0;
      t = (a * 146688 + (64'sd5 <<< 30)) / (64'sd10 <<< 30);
      return (t > longint'(ANGLE_MAX)) ? longint'(ANGLE_MAX) : t;
   endfunction

   function automatic longint coeff_term(int term, bit up);
      logic [31:0] half;
      if (term >= NUM_PAIRS) return 0;
      half = up ? coeff_pairs[term][63:32] : coeff_pairs[term][31:0];
      return longint'($signed(half));
   endfunction

   function automatic longint acc_clamp(longint v);
      if (v > 64'sd549755813887) return 64'sd549755813887;
      if (v < -64'sd549755813888) return -64'sd549755813888;
      return v;
   endfunction

   function automatic correction_type correct_track(track_type tr);
      correction_type res;
      longint px, py, pz, vz, p, rho, th, acc;
      longint unsigned perp2, corr;
      bit up;
      px = longint'($signed(tr.px));
      py = longint'($signed(tr.py));
      pz = longint'($signed(tr.pz));
      vz = longint'($signed(tr.vertex_z));
      perp2 = longint'(px * px) + longint'(py * py);
      p = longint'(isqrt(perp2 + longint'(pz * pz)));
      rho = longint'(isqrt(perp2 << 16));
      th = angle_q8_8(pz * 256, rho);
      if (th >= 70 * 256)
         up = 1'b1;
      else if (th < 30 * 256 || 20 * vz >= th - 10240 || th * 256 + 200 * p <= 86 * 65536)
         up = 1'b0;
      else if (th > 20 * vz + 50 * 256)
         up = 1'b1;
      else
         up = !(100 * p < 57 * 65536);
      // Horner with per-step clamp
      acc = acc_clamp(coeff_term(POLY_TERMS - 1, up));
      for (int i = POLY_TERMS - 2; i >= 0; i--)
         acc = acc_clamp(((acc * p) >>> 16) + coeff_term(i, up));
      if (acc < 0) acc = 0;
      corr = (longint'(p) * (64'd1 << 24) + longint'(p) * longint'(acc)) >> 24;
      res.saturated = 1'b0;
      if (corr > 64'hFFFFFF) begin
         corr = 64'hFFFFFF;
         res.saturated = 1'b1;
      end
      res.corrected_momentum = corr[23:0];
      res.raw_momentum       = p[23:0];
      res.polar_angle        = th[15:0];
      res.used_up_branch     = up;
      return res;
   endfunction

   task automatic report(string field, longint got, longint want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
   endtask

   // ---------------- sampling at rising edge ----------------
   always @(posedge clock) begin
      correction_type want;
      track_taken = 1'b0;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            track_taken = 1'b1;
            expected_results.push_back(correct_track(req_if.data));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               report("unexpected beat", 0, 0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_if.data.corrected_momentum !== want.corrected_momentum)
                  report("corrected_momentum", rsp_if.data.corrected_momentum,
                         want.corrected_momentum);
               if (rsp_if.data.raw_momentum !== want.raw_momentum)
                  report("raw_momentum", rsp_if.data.raw_momentum, want.raw_momentum);
               if (rsp_if.data.polar_angle !== want.polar_angle)
                  report("polar_angle", rsp_if.data.polar_angle, want.polar_angle);
               if (rsp_if.data.used_up_branch !== want.used_up_branch)
                  report("used_up_branch", rsp_if.data.used_up_branch, want.used_up_branch);
               if (rsp_if.data.saturated !== want.saturated)
                  report("saturated", rsp_if.data.saturated, want.saturated);
            end
         end
      end
   end

   // ---------------- track driver ----------------
   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || track_taken) begin
         if (pending_tracks.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_if.data  <= pending_tracks.pop_front();
            req_if.valid <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------- result receiver ----------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_arm != hold_seen) begin
         hold_seen = hold_arm;
         hold_left = LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // ---------------- stimulus ----------------
   task automatic write_coeffs(logic [63:0] c0, logic [63:0] c1, logic [63:0] c2,
                               logic [63:0] c3, logic [63:0] c4, logic [63:0] c5);
      logic [63:0] vals [NUM_PAIRS + 2];
      vals = '{c0, c1, c2, c3, c4, c5, {$urandom, $urandom}, {$urandom, $urandom}};
      for (int i = 0; i < NUM_PAIRS + 2; i++) begin
         @(negedge clock);
         csr_write_enable <= 1'b1;
         csr_index        <= csr_index_type'(i);
         csr_write_data   <= vals[i];
         if (i < NUM_PAIRS) coeff_pairs[i] = vals[i];
      end
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [63:0] mild_pair();
      logic [31:0] up, dn;
      up = 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
      dn = 32'($urandom_range(0, 1 << 23)) - 32'(1 << 22);
      return {up, dn};
   endfunction

   function automatic track_type make_track(int lo, int hi);
      track_type tr;
      tr.px = 24'($urandom_range(0, hi - lo)) + 24'(lo);
      tr.py = 24'($urandom_range(0, hi - lo)) + 24'(lo);
      tr.pz = 24'($urandom_range(0, hi - lo)) + 24'(lo);
      tr.vertex_z = 16'($urandom_range(0, 4096)) - 16'd2048;
      return tr;
   endfunction

   task automatic queue_random(int count);
      track_type tr;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0, 1: begin
               tr = track_type'(88'({$urandom, $urandom, $urandom}));
            end
            2: begin
               tr = make_track(-8192, 8192);
               tr.vertex_z = 16'($urandom);
            end
            default: begin
               tr = make_track(-(3 << 16), 3 << 16);
            end
         endcase
         pending_tracks.push_back(tr);
      end
   endtask

   task automatic queue_directed();
      pending_tracks.push_back('{24'h0, 24'h0, 24'h0, 16'h0});
      pending_tracks.push_back('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF});
      pending_tracks.push_back('{24'h800000, 24'h800000, 24'h800000, 16'h8000});
      pending_tracks.push_back('{24'h0, 24'h0, 24'h7FFFFF, 16'h0});
      pending_tracks.push_back('{24'h0, 24'h0, 24'h800000, 16'h0});
      pending_tracks.push_back('{24'h10000, 24'h0, 24'h0, 16'h0});
      pending_tracks.push_back('{24'h0, 24'h10000, 24'hFF0000, 16'h0});
      pending_tracks.push_back('{24'h1, 24'h0, 24'h0, 16'h0});
      pending_tracks.push_back('{24'h0, 24'h0, 24'hFFFFFF, 16'hFFFF});
      // mid angles near branch boundaries, vertex sweep
      pending_tracks.push_back('{24'h10000, 24'h0, 24'h10000, 16'h0});
      pending_tracks.push_back('{24'h10000, 24'h0, 24'h10000, 16'hFE00});
      pending_tracks.push_back('{24'h8000, 24'h0, 24'h8000, 16'hFB00});
      pending_tracks.push_back('{24'h4000, 24'h0, 24'h4000, 16'hFB00});
      pending_tracks.push_back('{24'h20000, 24'h0, 24'h30000, 16'hF800});
      pending_tracks.push_back('{24'h20000, 24'h0, 24'h20000, 16'hF800});
      pending_tracks.push_back('{24'h8000, 24'h0, 24'h10000, 16'h8000});
      pending_tracks.push_back('{24'h30000, 24'h10000, 24'h60000, 16'h0100});
      pending_tracks.push_back('{24'h10000, 24'h0, 24'h1000, 16'h0});
      pending_tracks.push_back('{24'h7FFFFF, 24'h0, 24'h0, 16'h0});
      pending_tracks.push_back('{24'h0, 24'h800000, 24'h0, 16'h0});
   endtask

   task automatic drain();
      while (pending_tracks.size() != 0 || req_if.valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      for (int i = 0; i < NUM_PAIRS; i++) coeff_pairs[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset coefficients, no idling
      queue_directed();
      queue_random(200);
      drain();

      // mild coefficients, sender idle
      write_coeffs(mild_pair(), mild_pair(), mild_pair(), mild_pair(), mild_pair(),
                   mild_pair());
      sender_idle_pct = 66;
      queue_directed();
      queue_random(280);
      drain();

      // extremes: max positive up, most negative down; receiver stalls
      write_coeffs({32'h7FFFFFFF, 32'h80000000}, {32'h7FFFFFFF, 32'h80000000},
                   {32'h7FFFFFFF, 32'h80000000}, {32'h7FFFFFFF, 32'h80000000},
                   {32'h7FFFFFFF, 32'h80000000}, {32'h7FFFFFFF, 32'h80000000});
      sender_idle_pct = 0;
      receiver_stall_pct = 66;
      queue_directed();
      queue_random(280);
      drain();

      // mirrored extremes, both sides idle, long receiver hold
      write_coeffs({32'h80000000, 32'h7FFFFFFF}, {32'h80000000, 32'h7FFFFFFF},
                   {32'h80000000, 32'h7FFFFFFF}, {32'h80000000, 32'h7FFFFFFF},
                   {32'h80000000, 32'h7FFFFFFF}, {32'h80000000, 32'h7FFFFFFF});
      sender_idle_pct = 18;
      receiver_stall_pct = 18;
      hold_arm = hold_arm + 1;
      queue_directed();
      queue_random(280);
      drain();

      // fully random coefficients, no idling
      write_coeffs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      queue_random(200);
      drain();

      if (error_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

   initial begin
      #5000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
`default_nettype wire

[sim.f]
rtl/pmc_pkg.sv
rtl/pmc_stream_if.sv
rtl/pmc_sqrt_stage.sv
rtl/proton_momentum_correction_unit.sv
test/tb_top.sv
